FILE: sv/assert_macros.svh
// Assertion macros shared by the octave noise RTL.
// Clock and active-low reset are passed in by the user of each macro.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: sv/ognz_pkg.sv
// Shared types and constants for the octave gradient noise block.
// No dependencies.
`default_nettype none

package ognz_pkg;

	localparam int TBL_DEPTH = 256;
	localparam int TBL_AW    = 8;
	localparam int TBL_W     = 8;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_EVAL  = 1'b1;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PERSISTENCE  = 1'd1;

	localparam int OCT_CNT_W = 4;
	localparam int PERS_W    = 16;
	localparam logic [OCT_CNT_W-1:0] OCT_CNT_RESET = 4'd8;
	localparam logic [PERS_W-1:0]    PERS_RESET    = 16'd32768;

	localparam int AMP_W    = 17;
	localparam int AMP_FRAC = 16;
	localparam logic [AMP_W-1:0] AMP_ONE = 17'h10000;

	localparam int OUT_W    = 18;
	localparam int OUT_FRAC = 16;
	localparam int QUO_W    = OUT_W + 1;
	localparam logic [OUT_W-1:0] OUT_MAX     = 18'h1FFFF;
	localparam logic [OUT_W-1:0] OUT_MIN     = 18'h20000;
	localparam logic [QUO_W-1:0] OUT_POS_LIM = 19'd131071;
	localparam logic [QUO_W-1:0] OUT_NEG_LIM = 19'd131072;

	// quintic ease coefficients
	localparam int EASE_C6  = 6;
	localparam int EASE_C15 = 15;
	localparam int EASE_C10 = 10;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

FILE: sv/octave_gradient_noise_3d.sv
// Octave gradient noise top level: sequencer, shared multiplier, permutation RAM, divider.
// Depends on ognz_pkg, ognz_ram, ognz_div and assert_macros.svh.
//
// Input channel (in_valid/in_stall): a write word (command 0) stores entry_value at
// entry_index of the permutation table in the accepting cycle; an evaluate word
// (command 1) carries unsigned Q8.F x/y/z coordinates. Table entries must be written
// before an evaluate reads them.
// Output channel (out_valid/out_stall): one noise_value word, signed Q1.16, per evaluate.
// Config port: cfg_write with cfg_index 0 (octave_count) or 1 (persistence), idle only.
// Each octave runs ease, table, lerp and weighting steps in turn on the single
// shared multiplier and the one table read port; after the last octave come the
// bit-serial divide and the output load.
// One evaluate word is in work at a time; in_stall is high while it is, and drops as
// the result is loaded into the output register.
// Write words are held off by in_stall too.
// The result sits in an output register; a new word is accepted while it waits on a
// stalled receiver, and the next result waits until that register is taken.
// Reset clears the sequencer and output valid and loads octave_count 8, persistence
// 0.5; the permutation table is not cleared.
`default_nettype none
`include "assert_macros.svh"

module octave_gradient_noise_3d import ognz_pkg::*; #(
	parameter int MAX_OCTAVES   = 8,
	parameter int FRACTION_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  command,
	input  wire logic [23:0]           x_coord,
	input  wire logic [23:0]           y_coord,
	input  wire logic [23:0]           z_coord,
	input  wire logic [7:0]            entry_index,
	input  wire logic [7:0]            entry_value,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic signed [OUT_W-1:0]    noise_value,
	input  wire logic                  cfg_write,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int F    = FRACTION_BITS;
	localparam int CW   = 8 + F;
	localparam int VW   = F + 4;
	localparam int MW   = (F + 8 > 18) ? F + 8 : 18;
	localparam int QW   = F + 5;
	localparam int OCTW = $clog2(MAX_OCTAVES + 1);
	localparam int SUMW = AMP_W + OCTW;
	localparam int ACCW = VW + 18 + OCTW;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EASE = 3'd1;
	localparam logic [2:0] ST_TBL  = 3'd2;
	localparam logic [2:0] ST_MIX  = 3'd3;
	localparam logic [2:0] ST_ACC  = 3'd4;
	localparam logic [2:0] ST_DIV  = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	localparam logic [3:0] TBL_LAST   = 4'd14;
	localparam logic [3:0] TBL_CORNER = 4'd7;
	localparam logic [3:0] MIX_LAST   = 4'd13;

	logic [2:0]      state_q;
	logic [3:0]      cnt_q;
	logic [1:0]      ax_q;
	logic [OCTW-1:0] k_q, n_q;
	logic            out_valid_q;
	logic [OCT_CNT_W-1:0] octave_count_q;
	logic [PERS_W-1:0]    persistence_q;

	logic [CW-1:0]   cx_q, cy_q, cz_q;
	logic [F:0]      sx_q, sy_q, sz_q;
	logic [QW-1:0]   q_q;
	logic [7:0]      ha_q, hb_q, haa_q, hab_q, hba_q, hbb_q;
	logic signed [VW-1:0] val_q [8];
	logic signed [ACCW-1:0] acc_q;
	logic [SUMW-1:0] amp_sum_q;
	logic [AMP_W-1:0] amp_q;
	logic signed [2*MW-1:0] p_q;
	logic [OUT_W-1:0] noise_value_q;

	logic            in_acc, tbl_we, last_oct, div_start, out_ld;
	logic [OCTW-1:0] n_eff;
	logic [7:0]      ix, iy, iz, raddr, rdata;
	logic [F-1:0]    fx, fy, fz, t_cur, t2;
	logic [QW-1:0]   q_pos, q_neg, q_new;
	logic [2:0]      vidx, mc, mix_dst;
	logic [F:0]      mix_s;
	logic signed [VW-1:0] mix_a, mix_b, dot;
	logic signed [VW:0]   mix_d;
	logic signed [MW-1:0] mul_a, mul_b;
	logic signed [F+1:0]  dx, dy, dz;
	div_stat_t       div_stat;
	logic [OUT_W-1:0] div_quo;

	function automatic logic signed [VW-1:0] corner_dot(
		input logic [3:0]          sel,
		input logic signed [F+1:0] ox,
		input logic signed [F+1:0] oy,
		input logic signed [F+1:0] oz
	);
		logic signed [VW-1:0] first, second, r;
		first  = (sel < 4'd8) ? VW'(ox) : VW'(oy);
		second = (sel < 4'd4) ? VW'(oy) :
			((sel == 4'd12 || sel == 4'd14) ? VW'(ox) : VW'(oz));
		r = sel[0] ? -first : first;
		return sel[1] ? r - second : r + second;
	endfunction

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign tbl_we    = in_acc && command == CMD_WRITE;
	assign last_oct  = (k_q == OCTW'(n_q - 1'b1));
	assign div_start = (state_q == ST_ACC) && (cnt_q == 4'd2) && last_oct;
	assign out_ld    = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	assign ix = cx_q[F +: 8];
	assign iy = cy_q[F +: 8];
	assign iz = cz_q[F +: 8];
	assign fx = cx_q[F-1:0];
	assign fy = cy_q[F-1:0];
	assign fz = cz_q[F-1:0];
	assign vidx = 3'(cnt_q - TBL_CORNER);
	assign mc   = cnt_q[3:1];
	assign t2   = p_q[F +: F];

	always_comb begin
		if (octave_count_q == '0) begin
			n_eff = OCTW'(1);
		end else if (int'(octave_count_q) > MAX_OCTAVES) begin
			n_eff = OCTW'(MAX_OCTAVES);
		end else begin
			n_eff = OCTW'(octave_count_q);
		end
	end

	always_comb begin
		unique case (ax_q)
			2'd0: t_cur = fx;
			2'd1: t_cur = fy;
			default: t_cur = fz;
		endcase
		q_pos = QW'(t2) * QW'(EASE_C6) + (QW'(EASE_C10) << F);
		q_neg = QW'(t_cur) * QW'(EASE_C15);
		q_new = (q_pos >= q_neg) ? q_pos - q_neg : '0;
	end

	// corner offsets: bit 0/1/2 of the corner picks x/y/z minus one
	always_comb begin
		dx  = vidx[0] ? {2'b11, fx} : {2'b00, fx};
		dy  = vidx[1] ? {2'b11, fy} : {2'b00, fy};
		dz  = vidx[2] ? {2'b11, fz} : {2'b00, fz};
		dot = corner_dot(rdata[3:0], dx, dy, dz);
	end

	always_comb begin
		unique case (mc)
			3'd0: begin mix_s = sx_q; mix_a = val_q[0]; mix_b = val_q[1]; mix_dst = 3'd0; end
			3'd1: begin mix_s = sx_q; mix_a = val_q[2]; mix_b = val_q[3]; mix_dst = 3'd2; end
			3'd2: begin mix_s = sx_q; mix_a = val_q[4]; mix_b = val_q[5]; mix_dst = 3'd4; end
			3'd3: begin mix_s = sx_q; mix_a = val_q[6]; mix_b = val_q[7]; mix_dst = 3'd6; end
			3'd4: begin mix_s = sy_q; mix_a = val_q[0]; mix_b = val_q[2]; mix_dst = 3'd0; end
			3'd5: begin mix_s = sy_q; mix_a = val_q[4]; mix_b = val_q[6]; mix_dst = 3'd4; end
			default: begin
				mix_s = sz_q; mix_a = val_q[0]; mix_b = val_q[4]; mix_dst = 3'd0;
			end
		endcase
		mix_d = (VW+1)'(mix_b) - (VW+1)'(mix_a);
	end

	always_comb begin
		unique case (cnt_q)
			4'd0:  raddr = ix;
			4'd1:  raddr = ix + 8'd1;
			4'd2:  raddr = ha_q;
			4'd3:  raddr = ha_q + 8'd1;
			4'd4:  raddr = hb_q;
			4'd5:  raddr = hb_q + 8'd1;
			4'd6:  raddr = haa_q;
			4'd7:  raddr = hba_q;
			4'd8:  raddr = hab_q;
			4'd9:  raddr = hbb_q;
			4'd10: raddr = haa_q + 8'd1;
			4'd11: raddr = hba_q + 8'd1;
			4'd12: raddr = hab_q + 8'd1;
			4'd13: raddr = hbb_q + 8'd1;
			default: raddr = ix;
		endcase
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_EASE: begin
				unique case (cnt_q)
					4'd0: begin mul_a = MW'(t_cur); mul_b = MW'(t_cur); end
					4'd1: begin mul_a = MW'(t2); mul_b = MW'(t_cur); end
					4'd2: begin mul_a = MW'(p_q[F +: F]); mul_b = MW'(q_q); end
					default: ;
				endcase
			end
			ST_MIX: begin
				if (!cnt_q[0]) begin
					mul_a = MW'(mix_s);
					mul_b = MW'(mix_d);
				end
			end
			ST_ACC: begin
				unique case (cnt_q)
					4'd0: begin mul_a = MW'(val_q[0]); mul_b = MW'(amp_q); end
					4'd1: begin mul_a = MW'(amp_q); mul_b = MW'(persistence_q); end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cnt_q          <= '0;
			ax_q           <= '0;
			k_q            <= '0;
			n_q            <= OCTW'(1);
			out_valid_q    <= 1'b0;
			octave_count_q <= OCT_CNT_RESET;
			persistence_q  <= PERS_RESET;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					REG_OCTAVE_COUNT: octave_count_q <= cfg_data[OCT_CNT_W-1:0];
					REG_PERSISTENCE:  persistence_q  <= cfg_data[PERS_W-1:0];
					default: ;
				endcase
			end
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && command == CMD_EVAL) begin
						state_q <= ST_EASE;
						cnt_q   <= '0;
						ax_q    <= '0;
						k_q     <= '0;
						n_q     <= n_eff;
					end
				end
				ST_EASE: begin
					if (cnt_q == 4'd3) begin
						cnt_q <= '0;
						if (ax_q == 2'd2) begin
							state_q <= ST_TBL;
							ax_q    <= '0;
						end else begin
							ax_q <= ax_q + 2'd1;
						end
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				ST_TBL: begin
					if (cnt_q == TBL_LAST) begin
						state_q <= ST_MIX;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				ST_MIX: begin
					if (cnt_q == MIX_LAST) begin
						state_q <= ST_ACC;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				ST_ACC: begin
					if (cnt_q == 4'd2) begin
						cnt_q <= '0;
						if (last_oct) begin
							state_q <= ST_DIV;
						end else begin
							state_q <= ST_EASE;
							k_q     <= k_q + 1'b1;
						end
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_ld) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		p_q <= mul_a * mul_b;
		if (state_q == ST_IDLE && in_acc && command == CMD_EVAL) begin
			cx_q      <= CW'(x_coord);
			cy_q      <= CW'(y_coord);
			cz_q      <= CW'(z_coord);
			acc_q     <= '0;
			amp_sum_q <= '0;
			amp_q     <= AMP_ONE;
		end
		if (state_q == ST_EASE) begin
			if (cnt_q == 4'd1) begin
				q_q <= q_new;
			end
			if (cnt_q == 4'd3) begin
				unique case (ax_q)
					2'd0: sx_q <= p_q[F +: F+1];
					2'd1: sy_q <= p_q[F +: F+1];
					default: sz_q <= p_q[F +: F+1];
				endcase
			end
		end
		if (state_q == ST_TBL) begin
			unique case (cnt_q)
				4'd1: ha_q  <= rdata + iy;
				4'd2: hb_q  <= rdata + iy;
				4'd3: haa_q <= rdata + iz;
				4'd4: hab_q <= rdata + iz;
				4'd5: hba_q <= rdata + iz;
				4'd6: hbb_q <= rdata + iz;
				default: ;
			endcase
			if (cnt_q >= TBL_CORNER) begin
				val_q[vidx] <= dot;
			end
		end
		if (state_q == ST_MIX && cnt_q[0]) begin
			val_q[mix_dst] <= mix_a + $signed(p_q[F +: VW]);
		end
		if (state_q == ST_ACC) begin
			if (cnt_q == 4'd1) begin
				acc_q     <= acc_q + ACCW'(p_q);
				amp_sum_q <= amp_sum_q + SUMW'(amp_q);
			end
			if (cnt_q == 4'd2) begin
				amp_q <= p_q[AMP_FRAC +: AMP_W];
				cx_q  <= {cx_q[CW-2:0], 1'b0};
				cy_q  <= {cy_q[CW-2:0], 1'b0};
				cz_q  <= {cz_q[CW-2:0], 1'b0};
			end
		end
		if (out_ld) begin
			noise_value_q <= div_quo;
		end
	end

	ognz_ram #(
		.WIDTH(TBL_W),
		.DEPTH(TBL_DEPTH)
	) u_perm (
		.clk  (clk),
		.we   (tbl_we),
		.waddr(entry_index),
		.wdata(entry_value),
		.raddr(raddr),
		.rdata(rdata)
	);

	ognz_div #(
		.ACC_W        (ACCW),
		.SUM_W        (SUMW),
		.FRACTION_BITS(F)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.acc    (acc_q),
		.amp_sum(amp_sum_q),
		.stat   (div_stat),
		.quo    (div_quo)
	);

	assign out_valid   = out_valid_q;
	assign noise_value = $signed(noise_value_q);

	`ASSERT_AT(a_out_from_seq, clk, arst_n, $rose(out_valid_q) |-> $past(state_q) == ST_OUT, "output word without finished evaluation")
	`ASSERT_AT(a_eval_starts, clk, arst_n, (in_acc && command == CMD_EVAL) |=> state_q == ST_EASE, "evaluate word did not start the sequencer")
	`ASSERT_AT(a_div_done_state, clk, arst_n, div_stat.done |-> state_q == ST_DIV, "divider finished outside divide phase")
	`ASSERT_AT(a_octave_range, clk, arst_n, state_q != ST_IDLE |-> k_q < n_q, "octave counter out of range")

endmodule

`default_nettype wire

FILE: sv/ognz_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ognz_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: sv/ognz_div.sv
// Bit-serial restoring divider for the final normalization, with saturation.
// Depends on ognz_pkg.
`default_nettype none

module ognz_div import ognz_pkg::*; #(
	parameter int ACC_W         = 48,
	parameter int SUM_W         = 21,
	parameter int FRACTION_BITS = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic signed [ACC_W-1:0] acc,
	input  wire logic [SUM_W-1:0]        amp_sum,
	output div_stat_t                    stat,
	output logic [OUT_W-1:0]             quo
);

	localparam int NW   = ACC_W + OUT_FRAC;
	localparam int DW   = SUM_W + FRACTION_BITS;
	localparam int CMPW = (NW > DW) ? NW : DW;
	localparam int CNTW = $clog2(QUO_W + 1);

	logic            run_q, done_q, neg_q, ovf_q;
	logic [CNTW-1:0] cnt_q;
	logic [DW-1:0]   rem_q, den_q;
	logic [QUO_W-1:0] qlow_q;
	logic [OUT_W-1:0] quo_q;

	logic [ACC_W-1:0] mag;
	logic [NW-1:0]    num;
	logic [DW-1:0]    den;
	logic             ovf, ge;
	logic [DW:0]      rem2;
	logic [OUT_W-1:0] sat;

	always_comb begin
		mag  = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
		num  = {mag, {OUT_FRAC{1'b0}}};
		den  = {amp_sum, {FRACTION_BITS{1'b0}}};
		ovf  = CMPW'(num >> QUO_W) >= CMPW'(den);
		rem2 = {rem_q, qlow_q[QUO_W-1]};
		ge   = rem2 >= {1'b0, den_q};
		if (neg_q) begin
			sat = (ovf_q || qlow_q > OUT_NEG_LIM) ? OUT_MIN : OUT_W'(-qlow_q);
		end else begin
			sat = (ovf_q || qlow_q > OUT_POS_LIM) ? OUT_MAX : OUT_W'(qlow_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNTW'(QUO_W);
			end else if (run_q) begin
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - 1'b1;
				end else begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q  <= acc[ACC_W-1];
			ovf_q  <= ovf;
			rem_q  <= DW'(num >> QUO_W);
			qlow_q <= num[QUO_W-1:0];
			den_q  <= den;
		end else if (run_q && cnt_q != '0) begin
			rem_q  <= ge ? DW'(rem2 - {1'b0, den_q}) : DW'(rem2);
			qlow_q <= {qlow_q[QUO_W-2:0], ge};
		end else if (run_q) begin
			quo_q <= sat;
		end
	end

	assign stat.busy = run_q;
	assign stat.done = done_q;
	assign quo       = quo_q;

endmodule

`default_nettype wire
